FILE: hw/rtl/gf2_13_arith_unit_top_defines.svh
// Assertion macros for the GF(2^13) unit
`ifndef GF2_13_ARITH_UNIT_TOP_DEFINES_SVH
`define GF2_13_ARITH_UNIT_TOP_DEFINES_SVH
`define GF_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("gf13 check failed");
`define GF_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("gf13 check failed");
`endif

FILE: hw/rtl/gf13_pkg.sv
package gf13_pkg;
    localparam int unsigned GfBits = 13;
    localparam logic [13:0] GfPoly = 14'h201b;
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_SQR = 2'd1;
    localparam logic [1:0] OP_INV = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;
    localparam int unsigned NumCells = 14;

    typedef logic [GfBits-1:0] gf_t;

    // cell operations
    localparam logic [1:0] CELL_PASS = 2'd0;
    localparam logic [1:0] CELL_SQ   = 2'd1;
    localparam logic [1:0] CELL_SQ2  = 2'd2;
    localparam logic [1:0] CELL_FIN  = 2'd3;

    typedef struct packed {
        logic       vld;
        logic [1:0] op;
        gf_t        a;
        gf_t        b;
        gf_t        p3;
        gf_t        p15;
        gf_t        acc;
    } gf_tok_t;

    function automatic gf_t gf_mul(input gf_t x, input gf_t y);
        logic [24:0] p;
        p = '0;
        for (int i = 0; i < GfBits; i++)
            if (y[i]) p = p ^ (25'(x) << i);
        for (int i = 24; i >= GfBits; i--)
            if (p[i]) p = p ^ (25'(GfPoly) << (i - GfBits));
        return p[GfBits-1:0];
    endfunction

    // squaring is linear: spread bits then reduce
    function automatic gf_t gf_sq(input gf_t x);
        logic [24:0] p;
        p = '0;
        for (int i = 0; i < GfBits; i++)
            p[2*i] = x[i];
        for (int i = 24; i >= GfBits; i--)
            if (p[i]) p = p ^ (25'(GfPoly) << (i - GfBits));
        return p[GfBits-1:0];
    endfunction
endpackage

FILE: hw/rtl/gf2_13_arith_unit_top.sv
// GF(2^13) multiply/square/invert/divide unit, x^13+x^4+x^3+x+1.
// Each transfer passes through all 14 registered cells before its result is valid.
// Throughput: one transfer per cycle, set by the 14-cell chain moving every cycle it is not held.
// The whole chain holds while a result waits under output stall; input stalls with it.
// Reset (rst_n, async low) clears all valid bits; no result after reset.
module gf2_13_arith_unit_top
    import gf13_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [12:0] operand_a,
    input  logic [12:0] operand_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [12:0] result
);
    `include "gf2_13_arith_unit_top_defines.svh"

    localparam int unsigned Stages = NumCells;

    gf_tok_t chain [Stages+1];
    logic    adv;

    assign adv = !(chain[Stages].vld && out_stall);
    assign in_stall = !adv;

    always_comb
    begin
        chain[0]     = '0;
        chain[0].vld = in_valid;
        chain[0].op  = req_type;
        chain[0].a   = operand_a;
        chain[0].b   = operand_b;
    end

    for (genvar g = 0; g < Stages; g++)
    begin : g_cell
        gf13_cell #(.STEP(4'(g))) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (adv),
            .tin  (chain[g]),
            .tout (chain[g+1])
        );
    end

    assign out_valid = chain[Stages].vld;
    assign result    = chain[Stages].acc;

    `GF_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(result))
    `GF_ASSERT_IMPL(a_stall, in_stall, out_valid && out_stall)
    `GF_ASSERT_NEXT(a_flow, in_valid && !in_stall, chain[1].vld)
endmodule

FILE: hw/rtl/gf13_cell.sv
module gf13_cell
    import gf13_pkg::*;
#(
    parameter logic [3:0] STEP = 4'd0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  gf_tok_t tin,
    output gf_tok_t tout
);
    gf_tok_t t_next;
    gf_tok_t t_reg;
    gf_t     sq1;
    gf_t     sq2;

    always_comb
    begin
        t_next = tin;
        sq1 = '0;
        sq2 = '0;
        case (STEP)
            4'd0:
            begin
                t_next.acc = gf_sq(tin.a);
            end
            4'd1:
            begin
                t_next.p3 = gf_mul(tin.acc, tin.a);
            end
            4'd2:
            begin
                sq1 = gf_sq(tin.p3);
                t_next.acc = gf_sq(sq1);
            end
            4'd3:
            begin
                t_next.p15 = gf_mul(tin.acc, tin.p3);
            end
            4'd4, 4'd5, 4'd8, 4'd9:
            begin
                sq1 = (STEP == 4'd4) ? tin.p15 : tin.acc;
                sq2 = gf_sq(sq1);
                t_next.acc = gf_sq(sq2);
            end
            4'd6, 4'd10:
            begin
                t_next.acc = gf_mul(tin.acc, tin.p15);
            end
            4'd7, 4'd11:
            begin
                t_next.p15 = tin.p15;
            end
            4'd12:
            begin
                t_next.acc = gf_sq(tin.acc);
            end
            4'd13:
            begin
                case (tin.op)
                    OP_MUL:  t_next.acc = gf_mul(tin.a, tin.b);
                    OP_SQR:  t_next.acc = gf_sq(tin.a);
                    OP_INV:  t_next.acc = tin.acc;
                    OP_DIV:  t_next.acc = gf_mul(tin.b, tin.acc);
                    default: t_next.acc = tin.acc;
                endcase
            end
            default:
            begin
                t_next = tin;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_reg <= '0;
        else if (en)
            t_reg <= t_next;
    end

    assign tout = t_reg;
endmodule

FILE: dv/gf2_13_arith_unit_top_test.sv
module gf2_13_arith_unit_top_test;
    import gf13_pkg::*;

    localparam int unsigned NumRandom = 1000;
    localparam int unsigned Latency   = 14;
    localparam int unsigned IdleLimit = 20000;

    typedef struct {
        logic [1:0]  op;
        logic [12:0] a;
        logic [12:0] b;
        logic        known;
        logic [12:0] res;
    } gf_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [12:0] operand_a;
    logic [12:0] operand_b;
    logic        out_valid;
    logic        out_stall;
    logic [12:0] result;

    logic [12:0] pending_results[$];
    gf_row_t     directed_rows[$];
    int unsigned mismatches;
    int unsigned idle_cycles;
    int unsigned sent_count;
    int unsigned recv_count;
    int unsigned op_count[4];
    logic        hold_off;

    gf2_13_arith_unit_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic logic [12:0] field_mul(logic [12:0] x, logic [12:0] y);
        logic [24:0] acc;
        acc = '0;
        for (int i = 0; i < 13; i++)
            if (y[i])
                acc ^= 25'(x) << i;
        for (int i = 24; i >= 13; i--)
            if (acc[i])
                acc ^= 25'h201b << (i - 13);
        return acc[12:0];
    endfunction

    // a^(2^13-2) by repeated squaring; 0 maps to 0
    function automatic logic [12:0] field_inverse(logic [12:0] x);
        logic [12:0] acc;
        logic [12:0] pw;
        acc = 13'd1;
        pw  = x;
        for (int i = 1; i < 13; i++)
        begin
            pw  = field_mul(pw, pw);
            acc = field_mul(acc, pw);
        end
        return acc;
    endfunction

    function automatic logic [12:0] field_op_result(logic [1:0] op, logic [12:0] a,
                                                    logic [12:0] b);
        case (op)
            OP_MUL:  return field_mul(a, b);
            OP_SQR:  return field_mul(a, a);
            OP_INV:  return field_inverse(a);
            default: return field_mul(b, field_inverse(a));
        endcase
    endfunction

    task automatic add_row(logic [1:0] op, logic [12:0] a, logic [12:0] b,
                           logic known = 1'b0, logic [12:0] res = '0);
        gf_row_t r;
        r.op = op;
        r.a = a;
        r.b = b;
        r.known = known;
        r.res = res;
        directed_rows.push_back(r);
    endtask

    // one transfer; expected value queued when accepted
    task automatic send_item(logic [1:0] op, logic [12:0] a, logic [12:0] b,
                             logic known, logic [12:0] res);
        in_valid  <= 1'b1;
        req_type  <= op;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(known ? res : field_op_result(op, a, b));
        op_count[op]++;
        sent_count++;
    endtask

    // receiver: own stall pattern plus one long hold-off
    initial
    begin
        int unsigned mode;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else
            begin
                mode = (recv_count / 150) % 3;
                if (mode == 0)
                    out_stall <= 1'b0;
                else if (mode == 1)
                    out_stall <= ($urandom_range(0, 3) == 0);
                else
                    out_stall <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            recv_count <= recv_count + 1;
            if (pending_results.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected transfer: result=%h", result);
            end
            else
            begin
                if (result !== pending_results[0])
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %h actual %h",
                                 pending_results[0], result);
                end
                void'(pending_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("watchdog expired");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        hold_off = 1'b0;
        @(posedge rst_n);
        repeat (40) @(posedge clk);
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        int unsigned burst;
        int unsigned k;
        logic [1:0]  op;
        logic [12:0] a;
        logic [12:0] b;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = '0;
        operand_a = '0;
        operand_b = '0;
        mismatches = 0;
        idle_cycles = 0;
        sent_count = 0;
        recv_count = 0;
        op_count = '{default: 0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(OP_MUL, 13'h0000, 13'h1fff, 1'b1, 13'h0000);
        add_row(OP_MUL, 13'h0001, 13'h1fff, 1'b1, 13'h1fff);
        add_row(OP_MUL, 13'h1fff, 13'h0001, 1'b1, 13'h1fff);
        add_row(OP_MUL, 13'h1fff, 13'h1fff);
        add_row(OP_MUL, 13'h1000, 13'h0002, 1'b1, 13'h001b);
        add_row(OP_SQR, 13'h0000, 13'h1fff, 1'b1, 13'h0000);
        add_row(OP_SQR, 13'h0001, 13'h1fff, 1'b1, 13'h0001);
        add_row(OP_SQR, 13'h1fff, 13'h0000);
        add_row(OP_SQR, 13'h1fff, 13'h1fff);
        add_row(OP_INV, 13'h0000, 13'h1fff, 1'b1, 13'h0000);
        add_row(OP_INV, 13'h0001, 13'h0000, 1'b1, 13'h0001);
        add_row(OP_INV, 13'h0002, 13'h1234);
        add_row(OP_INV, 13'h1fff, 13'h0000);
        add_row(OP_INV, 13'h1fff, 13'h1fff);
        add_row(OP_DIV, 13'h0000, 13'h1fff, 1'b1, 13'h0000);
        add_row(OP_DIV, 13'h0000, 13'h0001, 1'b1, 13'h0000);
        add_row(OP_DIV, 13'h0001, 13'h1fff, 1'b1, 13'h1fff);
        add_row(OP_DIV, 13'h1fff, 13'h1fff, 1'b1, 13'h0001);
        add_row(OP_DIV, 13'h1fff, 13'h0000, 1'b1, 13'h0000);
        add_row(OP_DIV, 13'h0002, 13'h1555);
        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].known, directed_rows[i].res);

        k = 0;
        while (k < NumRandom)
        begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && k < NumRandom; j++)
            begin
                op = 2'($urandom_range(0, 3));
                case ($urandom_range(0, 7))
                    0:       a = 13'($urandom_range(0, 3));
                    1:       a = 13'h1fff - 13'($urandom_range(0, 3));
                    default: a = 13'($urandom);
                endcase
                b = 13'($urandom);
                send_item(op, a, b, 1'b0, '0);
                k++;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (Latency + 10) @(posedge clk);

        $display("%0d transfers in, %0d out; mul %0d sqr %0d inv %0d div %0d",
                 sent_count, recv_count, op_count[0], op_count[1], op_count[2],
                 op_count[3]);
        $display("covered field extremes, zero inverse/divisor, bursts and a long output hold");
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
